// File: rtl/dae_pkg.sv
// Shared widths, types and constant functions for the dihedral angle pipeline.
package dae_pkg;

    localparam int COORD_W             = 32;
    localparam int NUM_COORDS          = 12;
    localparam int IN_DATA_W           = NUM_COORDS * COORD_W;
    localparam int OUT_DATA_W          = 24;
    localparam int COORD_FRAC_BITS_DEF = 20;

    localparam int DIF_W   = 33;
    localparam int PRD_W   = 66;
    localparam int NRM_W   = 67;
    localparam int LZ_W    = 7;
    localparam int THR_W   = 29;
    localparam int SQ_W    = 2 * THR_W;
    localparam int SQS_W   = 60;
    localparam int UNIT_W  = 30;
    localparam int U_W     = UNIT_W + 1;
    localparam int UP_W    = 2 * U_W;
    localparam int DOT_W   = 64;
    localparam int CRS_W   = 63;
    localparam int WMAG_W  = 62;
    localparam int HALF_W  = WMAG_W / 2;
    localparam int HP_W    = 2 * HALF_W;
    localparam int SS_W    = 126;
    localparam int XY_DROP = 20;
    localparam int RAD_W   = SS_W - 2 * XY_DROP;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int X_W     = DOT_W - XY_DROP;
    localparam int CRD_W   = 47;
    localparam int Z_W     = 36;
    localparam int CORDIC_STEPS = 32;
    localparam int ANGLE_W = 18;

    localparam logic [ANGLE_W-1:0]  ANGLE_MAX      = ANGLE_W'(205887);
    localparam logic signed [Z_W-1:0] PI_HALF_Q32    = 36'sh1921FB544;
    localparam logic signed [Z_W-1:0] PI_QUARTER_Q32 = 36'sh0C90FDAA2;

    typedef logic signed [DIF_W-1:0] t_dif;
    typedef logic signed [PRD_W-1:0] t_prd;
    typedef logic signed [NRM_W-1:0] t_nrm;
    typedef logic signed [U_W-1:0]   t_unit;
    typedef logic signed [CRD_W-1:0] t_crd;
    typedef logic signed [Z_W-1:0]   t_ang;

    typedef struct packed {
        logic                  deg;
        logic signed [X_W-1:0] x;
    } t_sq_side;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        int          b;
        rem = '0;
        q   = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q.32: pi/4 for i = 0, else from the alternating series in Q.60, rounded half up
    function automatic t_ang atan_q32(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        int          m;
        acc = '0;
        if (i == 0) begin
            return PI_QUARTER_Q32;
        end
        for (k = 0; k < 31; k++) begin
            m = 2 * k + 1;
            if (i * m <= 60) begin
                term = udiv64(64'd1 << (60 - i * m), 64'(m));
                if ((k & 1) != 0) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        return Z_W'((acc + 64'd134217728) >> 28);
    endfunction

endpackage

// File: rtl/dae_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module dae_sqrt import dae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_sq_side          i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_side          o_side
);

    logic             r_v    [ROOT_W];
    logic [RAD_W-1:0] r_op   [ROOT_W];
    logic [RAD_W-1:0] r_res  [ROOT_W];
    t_sq_side         r_side [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam logic [RAD_W-1:0] Bit = RAD_W'(1) << (2 * (ROOT_W - 1 - g));
        logic             v_in;
        logic [RAD_W-1:0] op_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] trial;
        t_sq_side         side_in;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign op_in   = i_rad;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign op_in   = r_op[g-1];
            assign res_in  = r_res[g-1];
            assign side_in = r_side[g-1];
        end

        assign trial = res_in + Bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g]    <= v_in;
                r_side[g] <= side_in;
                if (op_in >= trial) begin
                    r_op[g]  <= op_in - trial;
                    r_res[g] <= (res_in >> 1) + Bit;
                end else begin
                    r_op[g]  <= op_in;
                    r_res[g] <= res_in >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// File: rtl/dae_cordic.sv
// Pipelined vectoring CORDIC, one rotation per stage, angle accumulated in Q.32.
module dae_cordic import dae_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_crd i_x,
    input  t_crd i_y,
    input  t_ang i_z,
    input  logic i_deg,
    output logic o_valid,
    output t_ang o_z,
    output logic o_deg
);

    logic r_v   [CORDIC_STEPS];
    logic r_deg [CORDIC_STEPS];
    t_crd r_x   [CORDIC_STEPS];
    t_crd r_y   [CORDIC_STEPS];
    t_ang r_z   [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        localparam t_ang Ang = atan_q32(g);
        logic v_in;
        logic deg_in;
        t_crd x_in;
        t_crd y_in;
        t_ang z_in;
        t_crd dx;
        t_crd dy;

        if (g == 0) begin : g_first
            assign v_in   = i_valid;
            assign deg_in = i_deg;
            assign x_in   = i_x;
            assign y_in   = i_y;
            assign z_in   = i_z;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign deg_in = r_deg[g-1];
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
        end

        assign dx = y_in >>> g;
        assign dy = x_in >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g]   <= v_in;
                r_deg[g] <= deg_in;
                if (!y_in[CRD_W-1]) begin
                    r_x[g] <= x_in + dx;
                    r_y[g] <= y_in - dy;
                    r_z[g] <= z_in + Ang;
                end else begin
                    r_x[g] <= x_in - dx;
                    r_y[g] <= y_in + dy;
                    r_z[g] <= z_in - Ang;
                end
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_z     = r_z[CORDIC_STEPS-1];
    assign o_deg   = r_deg[CORDIC_STEPS-1];

endmodule

// File: rtl/dihedral_angle_of_edge.sv
// Dihedral angle of a shared mesh edge: top level with the normal and dot/cross pipeline.
//
// Each request carries four points (edge start, edge end, two wing vertices) and yields
// one angle between the two face normals in radians, unsigned Q2.16, with a degenerate
// flag when the edge or a normal is too short (angle then 0). One request is taken per
// clock while the output is not stalled. The pipeline runs through differences, cross
// products, normalization and dot/cross of the normals, the bit-per-stage square root,
// a quadrant-fix register, 32 CORDIC stages and the output register. A stalled output holds
// the whole pipeline; nothing is dropped or repeated.
module dihedral_angle_of_edge import dae_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // edge_start_x/y/z, edge_end_x/y/z, wing_a_x/y/z, wing_b_x/y/z, 32 bits each
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // angle [17:0], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // degenerate [0]
    output logic [0:0]            m_axis_tuser
);

    localparam logic [63:0] EdgeTol = (64'd1 << COORD_FRAC_BITS) / 64'd1000000;
    localparam logic [63:0] ThrRaw  =
        ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd500000) / 64'd1000000;
    localparam logic [THR_W-1:0] Thr = (ThrRaw == 64'd0) ? THR_W'(1) : THR_W'(ThrRaw);
    localparam logic [SQS_W-1:0] ThrSq = SQS_W'(Thr) * SQS_W'(Thr);
    localparam logic signed [DIF_W:0] TolPos = (DIF_W + 1)'(EdgeTol);
    localparam logic signed [DIF_W:0] TolNeg = -TolPos;

    function automatic logic [LZ_W-1:0] lead_zeros(input logic [NRM_W-1:0] v);
        logic [LZ_W-1:0] n;
        int              i;
        n = '0;
        for (i = 0; i < NRM_W; i++) begin
            if (v[i]) begin
                n = LZ_W'(NRM_W - 1 - i);
            end
        end
        return n;
    endfunction

    logic en;

    // stage 1: differences
    logic signed [COORD_W-1:0] p [NUM_COORDS];
    t_dif n_e [3];
    t_dif n_a [3];
    t_dif n_b [3];
    logic r_v1;
    t_dif r_e [3];
    t_dif r_a [3];
    t_dif r_b [3];

    // stage 2: cross-product terms, short edge
    logic n_edge_short;
    logic r_v2;
    logic r_deg2;
    t_prd r_pa [6];
    t_prd r_pb [6];

    // stage 3: normals
    logic r_v3;
    logic r_deg3;
    t_nrm r_n [6];

    // stage 4: magnitudes
    logic             r_v4;
    logic             r_deg4;
    logic [NRM_W-1:0] r_mag4 [6];
    logic             r_neg4 [6];
    logic             r_small4 [2];

    // stage 5: small-normal squares, leading zeros
    logic             r_v5;
    logic             r_deg5;
    logic [NRM_W-1:0] r_mag5 [6];
    logic             r_neg5 [6];
    logic             r_small5 [2];
    logic [SQ_W-1:0]  r_sq5 [6];
    logic [LZ_W-1:0]  r_lz5 [2];

    // stage 6: scaled normals
    logic             n_short [2];
    logic [NRM_W-1:0] n_shift [6];
    logic [UNIT_W-1:0] n_unit [6];
    logic             r_v6;
    logic             r_deg6;
    t_unit            r_u [6];

    // stage 7: products of the scaled normals
    logic                   r_v7;
    logic                   r_deg7;
    logic signed [UP_W-1:0] r_dp [3];
    logic signed [UP_W-1:0] r_cp [6];

    // stage 8: dot and cross
    logic                    r_v8;
    logic                    r_deg8;
    logic signed [DOT_W-1:0] r_dot8;
    logic signed [CRS_W-1:0] r_w8 [3];

    // stage 9: cross magnitudes
    logic                    r_v9;
    logic                    r_deg9;
    logic signed [DOT_W-1:0] r_dot9;
    logic [WMAG_W-1:0]       r_wm9 [3];

    // stage 10: half-word squares
    logic                    r_v10;
    logic                    r_deg10;
    logic signed [DOT_W-1:0] r_dot10;
    logic [HP_W-1:0]         r_hh [3];
    logic [HP_W-1:0]         r_hl [3];
    logic [HP_W-1:0]         r_ll [3];

    // stage 11: squared length, x
    logic [SS_W-1:0] n_ss;
    logic            r_v11;
    logic [RAD_W-1:0] r_rad;
    t_sq_side        r_side11;

    // square root
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_sq_side          sq_side;

    // quadrant fix
    logic r_v12;
    logic r_deg12;
    t_crd r_x12;
    t_crd r_y12;
    t_ang r_z12;

    // CORDIC
    logic cd_valid;
    t_ang cd_z;
    logic cd_deg;

    // output
    t_ang                n_zc;
    t_ang                n_zr;
    logic [ANGLE_W-1:0]  n_angle;
    logic                r_out_v;
    logic [ANGLE_W-1:0]  r_angle;
    logic                r_deg;

    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            p[k] = s_axis_tdata[COORD_W*k +: COORD_W];
        end
        for (int k = 0; k < 3; k++) begin
            n_e[k] = DIF_W'(p[3+k]) - DIF_W'(p[k]);
            n_a[k] = DIF_W'(p[6+k]) - DIF_W'(p[k]);
            n_b[k] = DIF_W'(p[9+k]) - DIF_W'(p[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_e  <= n_e;
            r_a  <= n_a;
            r_b  <= n_b;
        end
    end

    always_comb begin
        n_edge_short = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_e[k] > TolPos || r_e[k] < TolNeg) begin
                n_edge_short = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2     <= r_v1;
            r_deg2   <= n_edge_short;
            r_pa[0]  <= PRD_W'(r_e[1]) * PRD_W'(r_a[2]);
            r_pb[0]  <= PRD_W'(r_e[2]) * PRD_W'(r_a[1]);
            r_pa[1]  <= PRD_W'(r_e[2]) * PRD_W'(r_a[0]);
            r_pb[1]  <= PRD_W'(r_e[0]) * PRD_W'(r_a[2]);
            r_pa[2]  <= PRD_W'(r_e[0]) * PRD_W'(r_a[1]);
            r_pb[2]  <= PRD_W'(r_e[1]) * PRD_W'(r_a[0]);
            r_pa[3]  <= PRD_W'(r_b[1]) * PRD_W'(r_e[2]);
            r_pb[3]  <= PRD_W'(r_b[2]) * PRD_W'(r_e[1]);
            r_pa[4]  <= PRD_W'(r_b[2]) * PRD_W'(r_e[0]);
            r_pb[4]  <= PRD_W'(r_b[0]) * PRD_W'(r_e[2]);
            r_pa[5]  <= PRD_W'(r_b[0]) * PRD_W'(r_e[1]);
            r_pb[5]  <= PRD_W'(r_b[1]) * PRD_W'(r_e[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3   <= r_v2;
            r_deg3 <= r_deg2;
            for (int k = 0; k < 6; k++) begin
                r_n[k] <= NRM_W'(r_pa[k]) - NRM_W'(r_pb[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4   <= r_v3;
            r_deg4 <= r_deg3;
            for (int k = 0; k < 6; k++) begin
                r_neg4[k] <= r_n[k][NRM_W-1];
                r_mag4[k] <= r_n[k][NRM_W-1] ? NRM_W'(-r_n[k]) : NRM_W'(r_n[k]);
            end
            for (int j = 0; j < 2; j++) begin
                r_small4[j] <= (NRM_W'(r_n[3*j][NRM_W-1] ? -r_n[3*j] : r_n[3*j])
                                  < NRM_W'(Thr))
                    && (NRM_W'(r_n[3*j+1][NRM_W-1] ? -r_n[3*j+1] : r_n[3*j+1])
                                  < NRM_W'(Thr))
                    && (NRM_W'(r_n[3*j+2][NRM_W-1] ? -r_n[3*j+2] : r_n[3*j+2])
                                  < NRM_W'(Thr));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5     <= r_v4;
            r_deg5   <= r_deg4;
            r_mag5   <= r_mag4;
            r_neg5   <= r_neg4;
            r_small5 <= r_small4;
            for (int k = 0; k < 6; k++) begin
                r_sq5[k] <= SQ_W'(r_mag4[k][THR_W-1:0]) * SQ_W'(r_mag4[k][THR_W-1:0]);
            end
            for (int j = 0; j < 2; j++) begin
                r_lz5[j] <= lead_zeros(r_mag4[3*j] | r_mag4[3*j+1] | r_mag4[3*j+2]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_short[j] = r_small5[j] && ((SQS_W'(r_sq5[3*j]) + SQS_W'(r_sq5[3*j+1])
                                          + SQS_W'(r_sq5[3*j+2])) < ThrSq);
        end
        for (int k = 0; k < 6; k++) begin
            n_shift[k] = r_mag5[k] << r_lz5[k/3];
            n_unit[k]  = n_shift[k][NRM_W-1 -: UNIT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6   <= r_v5;
            r_deg6 <= r_deg5 || n_short[0] || n_short[1];
            for (int k = 0; k < 6; k++) begin
                r_u[k] <= r_neg5[k] ? -$signed({1'b0, n_unit[k]})
                                    : $signed({1'b0, n_unit[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v7    <= r_v6;
            r_deg7  <= r_deg6;
            for (int k = 0; k < 3; k++) begin
                r_dp[k] <= UP_W'(r_u[k]) * UP_W'(r_u[3+k]);
            end
            r_cp[0] <= UP_W'(r_u[1]) * UP_W'(r_u[5]);
            r_cp[1] <= UP_W'(r_u[2]) * UP_W'(r_u[4]);
            r_cp[2] <= UP_W'(r_u[2]) * UP_W'(r_u[3]);
            r_cp[3] <= UP_W'(r_u[0]) * UP_W'(r_u[5]);
            r_cp[4] <= UP_W'(r_u[0]) * UP_W'(r_u[4]);
            r_cp[5] <= UP_W'(r_u[1]) * UP_W'(r_u[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (en) begin
            r_v8   <= r_v7;
            r_deg8 <= r_deg7;
            r_dot8 <= DOT_W'(r_dp[0]) + DOT_W'(r_dp[1]) + DOT_W'(r_dp[2]);
            for (int k = 0; k < 3; k++) begin
                r_w8[k] <= CRS_W'(r_cp[2*k]) - CRS_W'(r_cp[2*k+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else if (en) begin
            r_v9   <= r_v8;
            r_deg9 <= r_deg8;
            r_dot9 <= r_dot8;
            for (int k = 0; k < 3; k++) begin
                r_wm9[k] <= r_w8[k][CRS_W-1] ? WMAG_W'(-r_w8[k]) : WMAG_W'(r_w8[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v10   <= r_v9;
            r_deg10 <= r_deg9;
            r_dot10 <= r_dot9;
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= HP_W'(r_wm9[k][WMAG_W-1:HALF_W]) * HP_W'(r_wm9[k][WMAG_W-1:HALF_W]);
                r_hl[k] <= HP_W'(r_wm9[k][WMAG_W-1:HALF_W]) * HP_W'(r_wm9[k][HALF_W-1:0]);
                r_ll[k] <= HP_W'(r_wm9[k][HALF_W-1:0]) * HP_W'(r_wm9[k][HALF_W-1:0]);
            end
        end
    end

    always_comb begin
        n_ss = '0;
        for (int k = 0; k < 3; k++) begin
            n_ss = n_ss + (SS_W'(r_hh[k]) << (2 * HALF_W))
                        + (SS_W'(r_hl[k]) << (HALF_W + 1))
                        + SS_W'(r_ll[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v11 <= 1'b0;
        end else if (en) begin
            r_v11        <= r_v10;
            r_rad        <= n_ss[SS_W-1 -: RAD_W];
            r_side11.deg <= r_deg10;
            r_side11.x   <= X_W'(r_dot10 >>> XY_DROP);
        end
    end

    dae_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v11),
        .i_rad   (r_rad),
        .i_side  (r_side11),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v12 <= 1'b0;
        end else if (en) begin
            r_v12   <= sq_valid;
            r_deg12 <= sq_side.deg;
            if (sq_side.x[X_W-1]) begin
                r_x12 <= CRD_W'({1'b0, sq_root});
                r_y12 <= -CRD_W'(sq_side.x);
                r_z12 <= PI_HALF_Q32;
            end else begin
                r_x12 <= CRD_W'(sq_side.x);
                r_y12 <= CRD_W'({1'b0, sq_root});
                r_z12 <= '0;
            end
        end
    end

    dae_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v12),
        .i_x     (r_x12),
        .i_y     (r_y12),
        .i_z     (r_z12),
        .i_deg   (r_deg12),
        .o_valid (cd_valid),
        .o_z     (cd_z),
        .o_deg   (cd_deg)
    );

    always_comb begin
        n_zc = cd_z[Z_W-1] ? '0 : cd_z;
        n_zr = (n_zc + Z_W'(32768)) >>> 16;
        if (cd_deg) begin
            n_angle = '0;
        end else if (n_zr > Z_W'(ANGLE_MAX)) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = n_zr[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= cd_valid;
            r_angle <= n_angle;
            r_deg   <= cd_deg;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {(OUT_DATA_W - ANGLE_W)'(0), r_angle};
    assign m_axis_tuser  = r_deg;

endmodule
